>>> rtl/kcf_pkg.sv
package kcf_pkg;

    localparam int MAX_FRAMES_DEF   = 1024;
    localparam int MAX_CHANNELS_DEF = 32;
    localparam int RES_CAP          = 32;

    localparam int FRAME_W   = 10;
    localparam int CHAN_W    = 5;
    localparam int TIME_W    = 32;
    localparam int COMP_W    = 8;
    localparam int RGBA_W    = 32;
    localparam int FCNT_W    = 11;
    localparam int CCNT_W    = 6;
    localparam int CFG_W     = 11;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;
    localparam int ACC_W     = 40;
    localparam int REM_W     = 41;

    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_COLOR  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_COLOR = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic REG_FRAME_COUNT   = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

endpackage

>>> rtl/kcf_blend.sv
module kcf_blend
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kcf_pkg::RGBA_W-1:0] c0,
    input  logic [kcf_pkg::RGBA_W-1:0] c1,
    input  logic [kcf_pkg::TIME_W-1:0] e,
    input  logic [kcf_pkg::TIME_W-1:0] d,
    output logic                       done,
    output logic [kcf_pkg::RGBA_W-1:0] rgba
);
    import kcf_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL0 = 3'd1;
    localparam logic [2:0] PH_MUL1 = 3'd2;
    localparam logic [2:0] PH_PREP = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;

    logic [2:0]        ph_reg;
    logic [1:0]        comp_reg;
    logic [2:0]        step_reg;
    logic [RGBA_W-1:0] c0_reg;
    logic [RGBA_W-1:0] c1_reg;
    logic [TIME_W-1:0] e_reg;
    logic [TIME_W-1:0] d_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  div_reg;
    logic [COMP_W-1:0] q_reg;
    logic [RGBA_W-1:0] rgba_reg;
    logic              done_reg;

    logic [4:0]        sh;
    logic [COMP_W-1:0] a;
    logic [COMP_W-1:0] b;
    logic              ge;
    logic [COMP_W-1:0] q_new;

    // red first: component k sits at bit 8*(3-k)
    assign sh    = {~comp_reg, 3'b000};
    assign a     = c0_reg[sh +: COMP_W];
    assign b     = c1_reg[sh +: COMP_W];
    assign ge    = rem_reg >= REM_W'(div_reg);
    assign q_new = {q_reg[COMP_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            comp_reg <= '0;
            step_reg <= '0;
            c0_reg   <= '0;
            c1_reg   <= '0;
            e_reg    <= '0;
            d_reg    <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            q_reg    <= '0;
            rgba_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (ph_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        c0_reg   <= c0;
                        c1_reg   <= c1;
                        e_reg    <= e;
                        d_reg    <= d;
                        comp_reg <= '0;
                        ph_reg   <= PH_MUL0;
                    end
                end
                PH_MUL0:
                begin
                    acc_reg <= ACC_W'(a) * ACC_W'(d_reg - e_reg);
                    ph_reg  <= PH_MUL1;
                end
                PH_MUL1:
                begin
                    acc_reg <= acc_reg + ACC_W'(b) * ACC_W'(e_reg);
                    ph_reg  <= PH_PREP;
                end
                PH_PREP:
                begin
                    rem_reg  <= {acc_reg, 1'b0} + REM_W'(d_reg);
                    div_reg  <= {d_reg, 8'b0};
                    q_reg    <= '0;
                    step_reg <= 3'd7;
                    ph_reg   <= PH_DIV;
                end
                PH_DIV:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - REM_W'(div_reg);
                    end
                    q_reg    <= q_new;
                    div_reg  <= div_reg >> 1;
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        rgba_reg <= {rgba_reg[RGBA_W-COMP_W-1:0], q_new};
                        if (comp_reg == 2'd3)
                        begin
                            done_reg <= 1'b1;
                            ph_reg   <= PH_IDLE;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                            ph_reg   <= PH_MUL0;
                        end
                    end
                end
                default:
                begin
                    ph_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rgba = rgba_reg;

endmodule

>>> rtl/keyframe_color_fader_unit.sv
// Keyframe colour player. Load items (tuser 0 header, 1 colour) write the frame
// stores and give one ack item. A query item (tuser 2) finds the last frame
// starting at or before the given time through the single header memory port:
// one end probe, up to three hint probes, then a binary search with a final
// probe and one or two header reads of the chosen frame, each probe a read
// state and a check state. Each channel then takes a colour read and the
// output handshake, plus a blend on a fading frame, where one shared
// multiply/restoring-divide unit works the four components in turn.
// The block takes no item until all results of the previous one are taken.
module keyframe_color_fader_unit #(
    parameter int MAX_FRAMES   = kcf_pkg::MAX_FRAMES_DEF,
    parameter int MAX_CHANNELS = kcf_pkg::MAX_CHANNELS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // frame_index, channel_index, start_ms, fade_flag, red_in, green_in,
    // blue_in, alpha_in, query_time_ms
    input  logic [kcf_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_frame, channel_out, red_out, green_out, blue_out, alpha_out, pad
    output logic [kcf_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_wen,
    input  logic                           cfg_addr,
    input  logic [kcf_pkg::CFG_W-1:0]      cfg_wdata
);
    import kcf_pkg::*;

    localparam int FAW    = $clog2(MAX_FRAMES);
    localparam int FCW    = $clog2(MAX_FRAMES + 1);
    localparam int IW     = FCW + 1;
    localparam int CDEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int CAP    = (MAX_CHANNELS < RES_CAP) ? MAX_CHANNELS : RES_CAP;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LAST_RD = 5'd1;
    localparam logic [4:0] S_LAST_CK = 5'd2;
    localparam logic [4:0] S_H0_RD   = 5'd3;
    localparam logic [4:0] S_H0_CK   = 5'd4;
    localparam logic [4:0] S_H1_RD   = 5'd5;
    localparam logic [4:0] S_H1_CK   = 5'd6;
    localparam logic [4:0] S_H2_RD   = 5'd7;
    localparam logic [4:0] S_H2_CK   = 5'd8;
    localparam logic [4:0] S_BS_RD   = 5'd9;
    localparam logic [4:0] S_BS_CK   = 5'd10;
    localparam logic [4:0] S_FIN_RD  = 5'd11;
    localparam logic [4:0] S_FIN_CK  = 5'd12;
    localparam logic [4:0] S_F0_RD   = 5'd13;
    localparam logic [4:0] S_F0_CK   = 5'd14;
    localparam logic [4:0] S_F1_RD   = 5'd15;
    localparam logic [4:0] S_F1_CK   = 5'd16;
    localparam logic [4:0] S_C0_RD   = 5'd17;
    localparam logic [4:0] S_C0_CK   = 5'd18;
    localparam logic [4:0] S_C1_CK   = 5'd19;
    localparam logic [4:0] S_BLEND   = 5'd20;
    localparam logic [4:0] S_OUT     = 5'd21;

    // input fields
    logic [FRAME_W-1:0] in_fi;
    logic [CHAN_W-1:0]  in_ci;
    logic [TIME_W-1:0]  in_start;
    logic               in_fade;
    logic [RGBA_W-1:0]  in_rgba;
    logic [TIME_W-1:0]  in_t;

    assign in_fi    = s_tdata[9:0];
    assign in_ci    = s_tdata[14:10];
    assign in_start = s_tdata[46:15];
    assign in_fade  = s_tdata[47];
    assign in_rgba  = {s_tdata[55:48], s_tdata[63:56], s_tdata[71:64], s_tdata[79:72]};
    assign in_t     = s_tdata[111:80];

    // memories
    logic [TIME_W:0]   hmem [MAX_FRAMES];
    logic [RGBA_W-1:0] cmem [CDEPTH];
    logic [TIME_W:0]   hrd_reg;
    logic [RGBA_W-1:0] crd_reg;
    logic [FAW-1:0]    hra;
    logic [CAW-1:0]    cra;
    logic              hwe;
    logic              cwe;
    logic [FAW-1:0]    hwa;
    logic [CAW-1:0]    cwa;

    // control and working registers
    logic [4:0]        state_reg;
    logic [FCNT_W-1:0] frame_count_reg;
    logic [CCNT_W-1:0] channel_count_reg;
    logic [TIME_W-1:0] t_reg;
    logic [FCW-1:0]    fc_reg;
    logic [CCNT_W-1:0] cc_reg;
    logic [FAW-1:0]    hint_reg;
    logic [IW-1:0]     first_reg;
    logic [IW-1:0]     last_reg;
    logic [FAW-1:0]    f_reg;
    logic [TIME_W-1:0] s0_reg;
    logic [TIME_W-1:0] d_reg;
    logic [TIME_W-1:0] e_reg;
    logic              fade_reg;
    logic [CAW-1:0]    base_reg;
    logic [CCNT_W-1:0] ch_reg;
    logic [RGBA_W-1:0] c0_reg;
    logic              m_tvalid_reg;
    logic [1:0]        o_kind_reg;
    logic [FRAME_W-1:0] o_frame_reg;
    logic [CHAN_W-1:0] o_ch_reg;
    logic [RGBA_W-1:0] o_rgba_reg;
    logic              o_last_reg;

    logic [FCW-1:0]    fc_now;
    logic [CCNT_W-1:0] cc_now;
    logic [IW-1:0]     fcx;
    logic [IW-1:0]     fcm1;
    logic [IW-1:0]     hx;
    logic [IW-1:0]     h1;
    logic [IW-1:0]     h2;
    logic [IW:0]       msum;
    logic [IW-1:0]     mid;
    logic [IW-1:0]     mid_p1;
    logic [IW-1:0]     mid_m1;
    logic [IW-1:0]     first_m1;
    logic [IW-1:0]     fx1;
    logic [TIME_W-1:0] s_rd;
    logic [31:0]       ca0;
    logic [31:0]       ca1;
    logic [31:0]       cwa32;
    logic [31:0]       base32;
    logic [31:0]       f32;
    logic [31:0]       hwa32;
    logic [TIME_W-1:0] e_raw;
    logic [TIME_W-1:0] d_new;
    logic              s_acc;
    logic              out_last;

    logic              blend_start;
    logic              blend_done;
    logic [RGBA_W-1:0] blend_rgba;

    always_comb
    begin
        if (32'(frame_count_reg) < 32'(MAX_FRAMES))
        begin
            fc_now = FCW'(frame_count_reg);
        end
        else
        begin
            fc_now = FCW'(MAX_FRAMES);
        end
        if (channel_count_reg == '0)
        begin
            cc_now = CCNT_W'(1);
        end
        else if (32'(channel_count_reg) > 32'(CAP))
        begin
            cc_now = CCNT_W'(CAP);
        end
        else
        begin
            cc_now = channel_count_reg;
        end
    end

    assign fcx      = IW'(fc_reg);
    assign fcm1     = fcx - IW'(1);
    assign hx       = IW'(hint_reg);
    assign h1       = hx + IW'(1);
    assign h2       = hx + IW'(2);
    assign msum     = {1'b0, first_reg} + {1'b0, last_reg};
    assign mid      = msum[IW:1];
    assign mid_p1   = mid + IW'(1);
    assign mid_m1   = mid - IW'(1);
    assign first_m1 = first_reg - IW'(1);
    assign fx1      = IW'(f_reg) + IW'(1);
    assign s_rd     = hrd_reg[TIME_W-1:0];
    assign ca0      = 32'(base_reg) + 32'(ch_reg);
    assign ca1      = ca0 + 32'(MAX_CHANNELS);
    assign cwa32    = 32'(in_fi) * 32'(MAX_CHANNELS) + 32'(in_ci);
    assign base32   = 32'(f_reg) * 32'(MAX_CHANNELS);
    assign f32      = 32'(f_reg);
    assign hwa32    = 32'(in_fi);
    assign e_raw    = (t_reg > s0_reg) ? (t_reg - s0_reg) : '0;
    assign d_new    = s_rd - s0_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_last = (ch_reg + CCNT_W'(1)) == cc_reg;

    assign hwe = s_acc && (s_tuser == MODE_HEADER) && (32'(in_fi) < 32'(MAX_FRAMES));
    assign cwe = s_acc && (s_tuser == MODE_COLOR) && (32'(in_fi) < 32'(MAX_FRAMES))
                 && (32'(in_ci) < 32'(MAX_CHANNELS));
    assign hwa = hwa32[FAW-1:0];
    assign cwa = cwa32[CAW-1:0];

    always_comb
    begin
        case (state_reg)
            S_LAST_RD: hra = fcm1[FAW-1:0];
            S_H0_RD:   hra = hx[FAW-1:0];
            S_H1_RD:   hra = h1[FAW-1:0];
            S_H2_RD:   hra = h2[FAW-1:0];
            S_BS_RD:   hra = mid[FAW-1:0];
            S_FIN_RD:  hra = first_reg[FAW-1:0];
            S_F0_RD:   hra = f_reg;
            S_F1_RD:   hra = fx1[FAW-1:0];
            default:   hra = '0;
        endcase
        case (state_reg)
            S_C0_CK: cra = ca1[CAW-1:0];
            default: cra = ca0[CAW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            hmem[hwa] <= {in_fade, in_start};
        end
        hrd_reg <= hmem[hra];
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
        begin
            cmem[cwa] <= in_rgba;
        end
        crd_reg <= cmem[cra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= '0;
            channel_count_reg <= CCNT_W'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_FRAME_COUNT:   frame_count_reg   <= cfg_wdata[FCNT_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[CCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign blend_start = (state_reg == S_C1_CK);

    kcf_blend u_blend
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .c0    (c0_reg),
        .c1    (crd_reg),
        .e     (e_reg),
        .d     (d_reg),
        .done  (blend_done),
        .rgba  (blend_rgba)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            t_reg        <= '0;
            fc_reg       <= '0;
            cc_reg       <= '0;
            hint_reg     <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            f_reg        <= '0;
            s0_reg       <= '0;
            d_reg        <= '0;
            e_reg        <= '0;
            fade_reg     <= 1'b0;
            base_reg     <= '0;
            ch_reg       <= '0;
            c0_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            o_kind_reg   <= KIND_ACK;
            o_frame_reg  <= '0;
            o_ch_reg     <= '0;
            o_rgba_reg   <= '0;
            o_last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        o_frame_reg <= '0;
                        o_ch_reg    <= '0;
                        o_rgba_reg  <= '0;
                        o_last_reg  <= 1'b1;
                        t_reg       <= in_t;
                        fc_reg      <= fc_now;
                        cc_reg      <= cc_now;
                        first_reg   <= '0;
                        last_reg    <= IW'(fc_now) - IW'(1);
                        case (s_tuser)
                            MODE_HEADER, MODE_COLOR:
                            begin
                                o_kind_reg   <= KIND_ACK;
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= S_OUT;
                            end
                            MODE_QUERY:
                            begin
                                if (fc_now == '0)
                                begin
                                    o_kind_reg   <= KIND_NONE;
                                    m_tvalid_reg <= 1'b1;
                                    state_reg    <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_LAST_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LAST_RD: state_reg <= S_LAST_CK;
                S_LAST_CK:
                begin
                    if (t_reg > s_rd)
                    begin
                        f_reg     <= fcm1[FAW-1:0];
                        state_reg <= S_F0_RD;
                    end
                    else if (hx < fcx)
                    begin
                        state_reg <= S_H0_RD;
                    end
                    else
                    begin
                        state_reg <= S_BS_RD;
                    end
                end
                S_H0_RD: state_reg <= S_H0_CK;
                S_H0_CK:
                begin
                    if (t_reg >= s_rd && h1 < fcx)
                    begin
                        state_reg <= S_H1_RD;
                    end
                    else
                    begin
                        state_reg <= S_BS_RD;
                    end
                end
                S_H1_RD: state_reg <= S_H1_CK;
                S_H1_CK:
                begin
                    if (t_reg < s_rd)
                    begin
                        f_reg     <= hint_reg;
                        state_reg <= S_F0_RD;
                    end
                    else if (h2 < fcx)
                    begin
                        state_reg <= S_H2_RD;
                    end
                    else
                    begin
                        state_reg <= S_BS_RD;
                    end
                end
                S_H2_RD: state_reg <= S_H2_CK;
                S_H2_CK:
                begin
                    if (t_reg < s_rd)
                    begin
                        f_reg     <= h1[FAW-1:0];
                        state_reg <= S_F0_RD;
                    end
                    else
                    begin
                        state_reg <= S_BS_RD;
                    end
                end
                S_BS_RD: state_reg <= S_BS_CK;
                S_BS_CK:
                begin
                    if (t_reg == s_rd)
                    begin
                        f_reg     <= mid[FAW-1:0];
                        state_reg <= S_F0_RD;
                    end
                    else if (t_reg > s_rd)
                    begin
                        first_reg <= mid_p1;
                        if ($signed(mid_p1) <= $signed(last_reg))
                        begin
                            state_reg <= S_BS_RD;
                        end
                        else if (mid_p1 >= fcx)
                        begin
                            f_reg     <= fcm1[FAW-1:0];
                            state_reg <= S_F0_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN_RD;
                        end
                    end
                    else
                    begin
                        last_reg <= mid_m1;
                        if ($signed(first_reg) <= $signed(mid_m1))
                        begin
                            state_reg <= S_BS_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN_RD;
                        end
                    end
                end
                S_FIN_RD: state_reg <= S_FIN_CK;
                S_FIN_CK:
                begin
                    if (t_reg < s_rd && first_reg == '0)
                    begin
                        hint_reg     <= '0;
                        o_kind_reg   <= KIND_NONE;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        f_reg     <= (t_reg < s_rd) ? first_m1[FAW-1:0] : first_reg[FAW-1:0];
                        state_reg <= S_F0_RD;
                    end
                end
                S_F0_RD: state_reg <= S_F0_CK;
                S_F0_CK:
                begin
                    hint_reg <= f_reg;
                    s0_reg   <= s_rd;
                    base_reg <= base32[CAW-1:0];
                    ch_reg   <= '0;
                    fade_reg <= 1'b0;
                    if (hrd_reg[TIME_W] && fx1 < fcx)
                    begin
                        state_reg <= S_F1_RD;
                    end
                    else
                    begin
                        state_reg <= S_C0_RD;
                    end
                end
                S_F1_RD: state_reg <= S_F1_CK;
                S_F1_CK:
                begin
                    fade_reg  <= s_rd > s0_reg;
                    d_reg     <= d_new;
                    e_reg     <= (e_raw > d_new) ? d_new : e_raw;
                    state_reg <= S_C0_RD;
                end
                S_C0_RD: state_reg <= S_C0_CK;
                S_C0_CK:
                begin
                    c0_reg      <= crd_reg;
                    o_kind_reg  <= KIND_COLOR;
                    o_frame_reg <= f32[FRAME_W-1:0];
                    o_ch_reg    <= ch_reg[CHAN_W-1:0];
                    o_last_reg  <= out_last;
                    if (fade_reg)
                    begin
                        state_reg <= S_C1_CK;
                    end
                    else
                    begin
                        o_rgba_reg   <= crd_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                S_C1_CK: state_reg <= S_BLEND;
                S_BLEND:
                begin
                    if (blend_done)
                    begin
                        o_rgba_reg   <= blend_rgba;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        if (o_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + CCNT_W'(1);
                            state_reg <= S_C0_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {1'b0, o_rgba_reg[7:0], o_rgba_reg[15:8], o_rgba_reg[23:16],
                       o_rgba_reg[31:24], o_ch_reg, o_frame_reg};

    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_ACK)) |-> m_tlast)
        else $error("ack or no-frame result without last");

    a_blend_owner: assert property (@(posedge clk) disable iff (!rst_n)
        blend_done |-> (state_reg == S_BLEND))
        else $error("blend finished outside blend wait");

endmodule
